@@ src/ulsp_pkg.sv @@
// shared constants, coefficient tables and exp rom for the link state probability pipeline
package ulsp_pkg;

  localparam int ULSP_COORD_BITS     = 24;
  localparam int ULSP_PROB_FRAC_BITS = 16;

  localparam logic [1:0] DENSITY_LOW    = 2'd0;
  localparam logic [1:0] DENSITY_MEDIUM = 2'd1;
  localparam logic [1:0] DENSITY_HIGH   = 2'd2;

  localparam logic [30:0] Q30_ONE   = 31'h4000_0000;
  localparam logic [30:0] LOG2E_Q30 = 31'd1549082005;
  localparam logic [29:0] LN2_Q30   = 30'd744261118;
  localparam logic [30:0] DIFF_MAX  = '1;

  typedef logic [30:0] exp_rom_t [17];

  localparam logic [29:0] COEF_A [3] = '{30'd917834511, 30'd898936647, 30'd962287423};
  localparam logic [18:0] COEF_B [3] = '{19'd107374, 19'd191260, 19'd285213};
  localparam logic signed [18:0] COEF_LNC [3] =
    '{-19'sd211611, -19'sd227235, -19'sd243886};
  localparam logic [18:0] COEF_M [3] = '{19'd345493, 19'd328093, 19'd328434};
  localparam logic [22:0] COEF_INVS [3] = '{23'd4817302, 23'd6835567, 23'd7594249};

  function automatic logic [63:0] const_isqrt(input logic [63:0] v);
    logic [63:0] rem;
    logic [63:0] root;
    logic [63:0] bitv;
    rem  = v;
    root = '0;
    for (int k = 31; k >= 0; k--) begin
      bitv = 64'd1 << (2 * k);
      if (rem >= root + bitv) begin
        rem  = rem - (root + bitv);
        root = (root >> 1) + bitv;
      end else begin
        root = root >> 1;
      end
    end
    return root;
  endfunction

  // entry 0 is one, entry i >= 1 is 2^(-2^-i) in q30
  function automatic exp_rom_t exp_rom_table();
    exp_rom_t rom;
    rom[0] = Q30_ONE;
    rom[1] = 31'(const_isqrt(64'd1 << 59));
    for (int i = 2; i <= 16; i++) begin
      rom[i] = 31'(const_isqrt(64'(rom[i-1]) << 30));
    end
    return rom;
  endfunction

  localparam exp_rom_t EXP_ROM = exp_rom_table();

endpackage

@@ src/ulsp_isqrt.sv @@
// pipelined integer square root, one root bit per stage
module ulsp_isqrt import ulsp_pkg::*; #(
  parameter int SW = 2
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          en,
  input  logic          in_valid,
  input  logic [63:0]   radicand,
  input  logic [SW-1:0] in_side,
  output logic          out_valid,
  output logic [31:0]   root,
  output logic [SW-1:0] out_side
);

  logic          vld_q  [32];
  logic [33:0]   rem_q  [32];
  logic [31:0]   root_q [32];
  logic [63:0]   rad_q  [32];
  logic [SW-1:0] side_q [32];

  logic          vld_in  [32];
  logic [33:0]   rem_in  [32];
  logic [31:0]   root_in [32];
  logic [63:0]   rad_in  [32];
  logic [SW-1:0] side_in [32];

  logic [33:0]   rem_next  [32];
  logic [31:0]   root_next [32];

  always_comb begin
    vld_in[0]  = in_valid;
    rem_in[0]  = '0;
    root_in[0] = '0;
    rad_in[0]  = radicand;
    side_in[0] = in_side;
    for (int k = 1; k < 32; k++) begin
      vld_in[k]  = vld_q[k-1];
      rem_in[k]  = rem_q[k-1];
      root_in[k] = root_q[k-1];
      rad_in[k]  = rad_q[k-1];
      side_in[k] = side_q[k-1];
    end
  end

  always_comb begin
    logic [35:0] r2;
    logic [35:0] trial;
    for (int k = 0; k < 32; k++) begin
      r2    = {rem_in[k], rad_in[k][63:62]};
      trial = {2'b00, root_in[k], 2'b01};
      if (r2 >= trial) begin
        rem_next[k]  = 34'(r2 - trial);
        root_next[k] = {root_in[k][30:0], 1'b1};
      end else begin
        rem_next[k]  = r2[33:0];
        root_next[k] = {root_in[k][30:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < 32; k++) vld_q[k] <= 1'b0;
    end else if (en) begin
      for (int k = 0; k < 32; k++) vld_q[k] <= vld_in[k];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 32; k++) begin
        rem_q[k]  <= rem_next[k];
        root_q[k] <= root_next[k];
        rad_q[k]  <= {rad_in[k][61:0], 2'b00};
        side_q[k] <= side_in[k];
      end
    end
  end

  assign out_valid = vld_q[31];
  assign root      = root_q[31];
  assign out_side  = side_q[31];

endmodule

@@ src/ulsp_log2.sv @@
// pipelined base-two logarithm of a distance in 1/16 m, q16 result by repeated squaring
module ulsp_log2 import ulsp_pkg::*; #(
  parameter int SW = 35
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               en,
  input  logic               in_valid,
  input  logic [31:0]        distance,
  input  logic [SW-1:0]      in_side,
  output logic               out_valid,
  output logic signed [21:0] log_val,
  output logic               out_zero,
  output logic [SW-1:0]      out_side
);

  logic [4:0]  lead;
  logic [31:0] norm;

  always_comb begin
    lead = '0;
    for (int i = 0; i < 32; i++) begin
      if (distance[i]) lead = 5'(i);
    end
  end

  assign norm = distance << (5'd31 - lead);

  logic          n_valid;
  logic [30:0]   n_mant;
  logic [4:0]    n_lead;
  logic          n_zero;
  logic [SW-1:0] n_side;

  always_ff @(posedge clk) begin
    if (rst) begin
      n_valid <= 1'b0;
    end else if (en) begin
      n_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      n_mant <= norm[31:1];
      n_lead <= lead;
      n_zero <= (distance == '0);
      n_side <= in_side;
    end
  end

  logic          vld_q  [16];
  logic [30:0]   mant_q [16];
  logic [15:0]   frac_q [16];
  logic [4:0]    lead_q [16];
  logic          zero_q [16];
  logic [SW-1:0] side_q [16];

  logic          vld_in  [16];
  logic [30:0]   mant_in [16];
  logic [15:0]   frac_in [16];
  logic [4:0]    lead_in [16];
  logic          zero_in [16];
  logic [SW-1:0] side_in [16];

  logic [30:0]   mant_next [16];
  logic [15:0]   frac_next [16];

  always_comb begin
    vld_in[0]  = n_valid;
    mant_in[0] = n_mant;
    frac_in[0] = '0;
    lead_in[0] = n_lead;
    zero_in[0] = n_zero;
    side_in[0] = n_side;
    for (int k = 1; k < 16; k++) begin
      vld_in[k]  = vld_q[k-1];
      mant_in[k] = mant_q[k-1];
      frac_in[k] = frac_q[k-1];
      lead_in[k] = lead_q[k-1];
      zero_in[k] = zero_q[k-1];
      side_in[k] = side_q[k-1];
    end
  end

  always_comb begin
    logic [61:0] sq;
    for (int k = 0; k < 16; k++) begin
      sq = 62'(mant_in[k]) * 62'(mant_in[k]);
      if (sq[61]) begin
        mant_next[k] = sq[61:31];
        frac_next[k] = {frac_in[k][14:0], 1'b1};
      end else begin
        mant_next[k] = sq[60:30];
        frac_next[k] = {frac_in[k][14:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < 16; k++) vld_q[k] <= 1'b0;
    end else if (en) begin
      for (int k = 0; k < 16; k++) vld_q[k] <= vld_in[k];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 16; k++) begin
        mant_q[k] <= mant_next[k];
        frac_q[k] <= frac_next[k];
        lead_q[k] <= lead_in[k];
        zero_q[k] <= zero_in[k];
        side_q[k] <= side_in[k];
      end
    end
  end

  logic [5:0] int_part;
  assign int_part = {1'b0, lead_q[15]} - 6'd4;

  assign out_valid = vld_q[15];
  assign log_val   = $signed({int_part, frac_q[15]});
  assign out_zero  = zero_q[15];
  assign out_side  = side_q[15];

endmodule

@@ src/ulsp_exp2.sv @@
// pipelined 2^(-y) in q30, one rom product per fraction bit then the integer shift
module ulsp_exp2 import ulsp_pkg::*; #(
  parameter int YW = 33,
  parameter int SW = 2
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          en,
  input  logic          in_valid,
  input  logic [YW-1:0] expo,
  input  logic [SW-1:0] in_side,
  output logic          out_valid,
  output logic [30:0]   value,
  output logic [SW-1:0] out_side
);

  localparam int NW = YW - 16;

  logic          vld_q  [16];
  logic [30:0]   val_q  [16];
  logic [15:0]   frac_q [16];
  logic [NW-1:0] int_q  [16];
  logic [SW-1:0] side_q [16];

  logic          vld_in  [16];
  logic [30:0]   val_in  [16];
  logic [15:0]   frac_in [16];
  logic [NW-1:0] int_in  [16];
  logic [SW-1:0] side_in [16];

  logic [30:0]   val_next [16];

  always_comb begin
    vld_in[0]  = in_valid;
    val_in[0]  = Q30_ONE;
    frac_in[0] = expo[15:0];
    int_in[0]  = expo[YW-1:16];
    side_in[0] = in_side;
    for (int k = 1; k < 16; k++) begin
      vld_in[k]  = vld_q[k-1];
      val_in[k]  = val_q[k-1];
      frac_in[k] = frac_q[k-1];
      int_in[k]  = int_q[k-1];
      side_in[k] = side_q[k-1];
    end
  end

  always_comb begin
    logic [61:0] prod;
    for (int k = 0; k < 16; k++) begin
      prod = 62'(val_in[k]) * 62'(EXP_ROM[k+1]);
      val_next[k] = frac_in[k][15-k] ? prod[60:30] : val_in[k];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < 16; k++) vld_q[k] <= 1'b0;
    end else if (en) begin
      for (int k = 0; k < 16; k++) vld_q[k] <= vld_in[k];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 16; k++) begin
        val_q[k]  <= val_next[k];
        frac_q[k] <= frac_in[k];
        int_q[k]  <= int_in[k];
        side_q[k] <= side_in[k];
      end
    end
  end

  logic          s_valid;
  logic [30:0]   s_value;
  logic [SW-1:0] s_side;

  always_ff @(posedge clk) begin
    if (rst) begin
      s_valid <= 1'b0;
    end else if (en) begin
      s_valid <= vld_q[15];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s_value <= (int_q[15] >= NW'(31)) ? '0 : (val_q[15] >> int_q[15]);
      s_side  <= side_q[15];
    end
  end

  assign out_valid = s_valid;
  assign value     = s_value;
  assign out_side  = s_side;

endmodule

@@ src/v2v_urban_link_state_probability.sv @@
// top level: v2v urban line-of-sight and vehicle-blocked probability pipeline
//
// s_axis carries one link per beat: two planar positions in 1/16 m. m_axis
// returns one beat per link with the clear, vehicle-blocked and remaining
// blocked probabilities in q1.16 (PROB_FRAC_BITS). cfg_valid/cfg_data set the
// vehicle density (low, medium, high; the unused code acts as high); write it
// only while no link is in flight.
// from input beat to output beat a link passes distance squaring (stages a,
// b and c), a 32-stage square root, the clear exponent (l1 to l3), a
// 17-stage log2, the blocked exponent (n1 to n6), two 17-stage exp units
// side by side, one scaling stage and the output register.
// throughput is one link per cycle while the output is not held. the whole
// pipeline moves together: when the output beat is held by the receiver every
// stage holds and s_axis_tready drops in the same cycle, so nothing is lost or repeated.
// reset empties the pipeline and sets the density to low.
module v2v_urban_link_state_probability import ulsp_pkg::*; #(
  parameter int COORD_BITS     = ULSP_COORD_BITS,
  parameter int PROB_FRAC_BITS = ULSP_PROB_FRAC_BITS
) (
  input  logic clk,
  input  logic rst,
  input  logic s_axis_tvalid,
  output logic s_axis_tready,
  // first_x, first_y, second_x, second_y
  input  logic [((4*COORD_BITS+7)/8)*8-1:0] s_axis_tdata,
  output logic m_axis_tvalid,
  input  logic m_axis_tready,
  // prob_clear, prob_vehicle_blocked, prob_blocked
  output logic [((3*PROB_FRAC_BITS+4+7)/8)*8-1:0] m_axis_tdata,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [1:0] cfg_data
);

  localparam int OUT_W  = ((3*PROB_FRAC_BITS+4+7)/8)*8;
  localparam int CW1    = COORD_BITS + 1;
  localparam int PW     = PROB_FRAC_BITS + 1;
  localparam int BW     = PROB_FRAC_BITS + 2;
  localparam int RND_SH = 30 - PROB_FRAC_BITS;
  localparam logic [31:0] RND_HALF = 32'd1 << (RND_SH - 1);
  localparam logic [BW-1:0] ONE_W  = BW'(1) << PROB_FRAC_BITS;

  logic [1:0] density;
  logic       adv;

  assign cfg_ready     = 1'b1;
  assign adv           = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      density <= DENSITY_LOW;
    end else if (cfg_valid) begin
      density <= cfg_data;
    end
  end

  // coordinate differences, their squares and the squared distance
  logic signed [COORD_BITS-1:0] fx, fy, sx, sy;
  logic signed [CW1-1:0] dfx, dfy;
  logic [CW1-1:0] mgx, mgy;
  logic [63:0] mgx64, mgy64;

  assign fx  = s_axis_tdata[0 +: COORD_BITS];
  assign fy  = s_axis_tdata[COORD_BITS +: COORD_BITS];
  assign sx  = s_axis_tdata[2*COORD_BITS +: COORD_BITS];
  assign sy  = s_axis_tdata[3*COORD_BITS +: COORD_BITS];
  assign dfx = CW1'(sx) - CW1'(fx);
  assign dfy = CW1'(sy) - CW1'(fy);
  assign mgx = dfx[CW1-1] ? $unsigned(-dfx) : $unsigned(dfx);
  assign mgy = dfy[CW1-1] ? $unsigned(-dfy) : $unsigned(dfy);
  assign mgx64 = 64'(mgx);
  assign mgy64 = 64'(mgy);

  logic        a_valid;
  logic [30:0] a_dx, a_dy;
  logic [1:0]  a_sel;
  logic        b_valid;
  logic [61:0] b_dx2, b_dy2;
  logic [1:0]  b_sel;
  logic        c_valid;
  logic [62:0] c_sum;
  logic [1:0]  c_sel;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
      b_valid <= 1'b0;
      c_valid <= 1'b0;
    end else if (adv) begin
      a_valid <= s_axis_tvalid;
      b_valid <= a_valid;
      c_valid <= b_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a_dx  <= (mgx64 > 64'(DIFF_MAX)) ? DIFF_MAX : mgx64[30:0];
      a_dy  <= (mgy64 > 64'(DIFF_MAX)) ? DIFF_MAX : mgy64[30:0];
      a_sel <= (density > DENSITY_HIGH) ? DENSITY_HIGH : density;
      b_dx2 <= 62'(a_dx) * 62'(a_dx);
      b_dy2 <= 62'(a_dy) * 62'(a_dy);
      b_sel <= a_sel;
      c_sum <= 63'(b_dx2) + 63'(b_dy2);
      c_sel <= b_sel;
    end
  end

  logic        sq_valid;
  logic [31:0] sq_root;
  logic [1:0]  sq_sel;

  ulsp_isqrt #(.SW(2)) u_isqrt (
    .clk       (clk),
    .rst       (rst),
    .en        (adv),
    .in_valid  (c_valid),
    .radicand  ({1'b0, c_sum}),
    .in_side   (c_sel),
    .out_valid (sq_valid),
    .root      (sq_root),
    .out_side  (sq_sel)
  );

  // clear exponent
  logic        l1_valid, l2_valid, l3_valid;
  logic [50:0] l1_bx;
  logic [31:0] l1_d16, l2_d16, l3_d16;
  logic [1:0]  l1_sel, l2_sel, l3_sel;
  logic [31:0] l2_x;
  logic [32:0] l3_ylos;
  logic [62:0] ylos_prod;

  assign ylos_prod = 63'(l2_x) * 63'(LOG2E_Q30);

  always_ff @(posedge clk) begin
    if (rst) begin
      l1_valid <= 1'b0;
      l2_valid <= 1'b0;
      l3_valid <= 1'b0;
    end else if (adv) begin
      l1_valid <= sq_valid;
      l2_valid <= l1_valid;
      l3_valid <= l2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      l1_bx   <= 51'(COEF_B[sq_sel]) * 51'(sq_root);
      l1_d16  <= sq_root;
      l1_sel  <= sq_sel;
      l2_x    <= (l1_bx[50:44] != '0) ? '1 : l1_bx[43:12];
      l2_d16  <= l1_d16;
      l2_sel  <= l1_sel;
      l3_ylos <= ylos_prod[62:30];
      l3_d16  <= l2_d16;
      l3_sel  <= l2_sel;
    end
  end

  logic               lg_valid;
  logic signed [21:0] lg_l;
  logic               lg_zero;
  logic [34:0]        lg_side;

  ulsp_log2 #(.SW(35)) u_log2 (
    .clk       (clk),
    .rst       (rst),
    .en        (adv),
    .in_valid  (l3_valid),
    .distance  (l3_d16),
    .in_side   ({l3_sel, l3_ylos}),
    .out_valid (lg_valid),
    .log_val   (lg_l),
    .out_zero  (lg_zero),
    .out_side  (lg_side)
  );

  // vehicle-blocked exponent
  logic [20:0] lg_mag;
  logic [50:0] lnm_prod;
  assign lg_mag   = lg_l[21] ? 21'(-lg_l) : lg_l[20:0];
  assign lnm_prod = 51'(lg_mag) * 51'(LN2_Q30);

  logic n1_valid, n2_valid, n3_valid, n4_valid, n5_valid, n6_valid;
  logic [34:0] n1_side, n2_side, n3_side, n4_side, n5_side, n6_side;
  logic n1_zero, n2_zero, n3_zero, n4_zero, n5_zero, n6_zero;
  logic        n1_neg;
  logic [20:0] n1_lnm;
  logic signed [21:0] n2_lnd, n3_lnd;
  logic [21:0] n2_dm;
  logic [27:0] n3_sq;
  logic [26:0] n4_term;
  logic signed [22:0] n4_base;
  logic signed [27:0] n5_e;
  logic n6_nonpos;
  logic [27:0] n6_ynv;

  logic signed [21:0] lnd_c;
  logic signed [22:0] dd_c;
  logic [1:0] n1_sel, n3_sel, n5_sel;
  logic [43:0] sq_prod;
  logic [50:0] term_prod;
  logic signed [27:0] e_c;
  logic [57:0] ynv_prod;

  assign n1_sel = n1_side[34:33];
  assign n3_sel = n3_side[34:33];
  assign n5_sel = n5_side[34:33];
  assign lnd_c  = n1_neg ? -$signed({1'b0, n1_lnm}) : $signed({1'b0, n1_lnm});
  assign dd_c   = 23'(lnd_c) - $signed({4'b0, COEF_M[n1_sel]});
  assign sq_prod   = 44'(n2_dm) * 44'(n2_dm);
  assign term_prod = 51'(n3_sq) * 51'(COEF_INVS[n3_sel]);
  assign e_c       = 28'(n4_base) + $signed({1'b0, n4_term});
  assign ynv_prod  = 58'(n5_e[26:0]) * 58'(LOG2E_Q30);

  always_ff @(posedge clk) begin
    if (rst) begin
      n1_valid <= 1'b0;
      n2_valid <= 1'b0;
      n3_valid <= 1'b0;
      n4_valid <= 1'b0;
      n5_valid <= 1'b0;
      n6_valid <= 1'b0;
    end else if (adv) begin
      n1_valid <= lg_valid;
      n2_valid <= n1_valid;
      n3_valid <= n2_valid;
      n4_valid <= n3_valid;
      n5_valid <= n4_valid;
      n6_valid <= n5_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      n1_neg    <= lg_l[21];
      n1_lnm    <= lnm_prod[50:30];
      n1_zero   <= lg_zero;
      n1_side   <= lg_side;
      n2_lnd    <= lnd_c;
      n2_dm     <= dd_c[22] ? 22'(-dd_c) : dd_c[21:0];
      n2_zero   <= n1_zero;
      n2_side   <= n1_side;
      n3_sq     <= sq_prod[43:16];
      n3_lnd    <= n2_lnd;
      n3_zero   <= n2_zero;
      n3_side   <= n2_side;
      n4_term   <= term_prod[50:24];
      n4_base   <= 23'(COEF_LNC[n3_sel]) + 23'(n3_lnd);
      n4_zero   <= n3_zero;
      n4_side   <= n3_side;
      n5_e      <= e_c;
      n5_zero   <= n4_zero;
      n5_side   <= n4_side;
      n6_nonpos <= n5_e[27] || (n5_e == '0);
      n6_ynv    <= ynv_prod[57:30];
      n6_zero   <= n5_zero;
      n6_side   <= {n5_sel, n5_side[32:0]};
    end
  end

  logic        exl_valid, exn_valid;
  logic [30:0] exl_value, exn_value;
  logic [1:0]  exl_sel, exn_flags;

  ulsp_exp2 #(.YW(33), .SW(2)) u_exp_clear (
    .clk       (clk),
    .rst       (rst),
    .en        (adv),
    .in_valid  (n6_valid),
    .expo      (n6_side[32:0]),
    .in_side   (n6_side[34:33]),
    .out_valid (exl_valid),
    .value     (exl_value),
    .out_side  (exl_sel)
  );

  ulsp_exp2 #(.YW(33), .SW(2)) u_exp_vehicle (
    .clk       (clk),
    .rst       (rst),
    .en        (adv),
    .in_valid  (n6_valid),
    .expo      (33'(n6_ynv)),
    .in_side   ({n6_zero, n6_nonpos}),
    .out_valid (exn_valid),
    .value     (exn_value),
    .out_side  (exn_flags)
  );

  // scaling and clamping in q30
  logic [60:0] plos_prod;
  assign plos_prod = 61'(COEF_A[exl_sel]) * 61'(exl_value);

  logic        e1_valid;
  logic [30:0] e1_plos, e1_pnv;

  always_ff @(posedge clk) begin
    if (rst) begin
      e1_valid <= 1'b0;
    end else if (adv) begin
      e1_valid <= exl_valid && exn_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      e1_plos <= (plos_prod[60:30] > Q30_ONE) ? Q30_ONE : plos_prod[60:30];
      if (exn_flags[1]) begin
        e1_pnv <= '0;
      end else if (exn_flags[0] || (exn_value > Q30_ONE)) begin
        e1_pnv <= Q30_ONE;
      end else begin
        e1_pnv <= exn_value;
      end
    end
  end

  // rounding to output precision and the remaining blocked probability
  logic [31:0]   rc_sum, rn_sum;
  logic [PW-1:0] pc_c, pn_c;
  assign rc_sum = 32'(e1_plos) + RND_HALF;
  assign rn_sum = 32'(e1_pnv) + RND_HALF;
  assign pc_c   = rc_sum[RND_SH +: PW];
  assign pn_c   = rn_sum[RND_SH +: PW];

  logic [PW-1:0] out_clear, out_vblock;
  logic [BW-1:0] out_blocked;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (adv) begin
      m_axis_tvalid <= e1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_clear   <= pc_c;
      out_vblock  <= pn_c;
      out_blocked <= ONE_W - BW'(pc_c) - BW'(pn_c);
    end
  end

  assign m_axis_tdata = OUT_W'({out_blocked, out_vblock, out_clear});

  a_reset_empty: assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("output beat valid right after reset");

  a_sum_to_one: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (out_blocked == ONE_W - BW'(out_clear) - BW'(out_vblock)))
    else $error("probabilities do not sum to one");

  a_prob_range: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (BW'(out_clear) <= ONE_W) && (BW'(out_vblock) <= ONE_W))
    else $error("probability above one");

  a_stall_blocks_input: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tready) |-> !s_axis_tready)
    else $error("input beat taken while output held");

endmodule
